[design/scan_range_jump_corner_detector_core_assert.svh]
// Assertion macros for the scan range jump corner detector
`ifndef SCAN_RANGE_JUMP_CORNER_DETECTOR_CORE_ASSERT_SVH
`define SCAN_RANGE_JUMP_CORNER_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication
`define SRJCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRJCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/srjcd_pkg.sv]
// Package: types, constants and sine table function of the corner detector
`default_nettype none

package srjcd_pkg;

  localparam int unsigned MAX_BEAMS_DEF    = 1024;
  localparam int unsigned SINE_ENTRIES_DEF = 1024;

  localparam int unsigned RANGE_W     = 16;
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned STEP_W      = 15;
  localparam int unsigned COORD_W     = 17;
  localparam int unsigned BEAM_IDX_W  = 10;
  localparam int unsigned SINE_W      = 15;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [ANGLE_W-1:0] START_ANGLE_RST  = 16'h8000;
  localparam logic [STEP_W-1:0]  ANGLE_STEP_RST   = 15'd182;
  localparam logic [RANGE_W-1:0] GAP_MIN_RST      = 16'd150;
  localparam logic [RANGE_W-1:0] NEAR_MAX_RST     = 16'd5000;
  localparam logic [RANGE_W-1:0] AXIS_JUMP_RST    = 16'd500;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN   = 16'h4000;
  localparam logic [ANGLE_W-1:0] FRONT_LOW_END  = 16'd16384;
  localparam logic [ANGLE_W-1:0] FRONT_HIGH_END = 16'd49152;

  // lookups: cos a0, sin a0, cos a1, sin a1; the counter runs one past the last
  localparam logic [2:0] LOOK_LAST = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ANGLE = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_GAP_MIN     = 3'd2,
    REG_NEAR_MAX    = 3'd3,
    REG_AXIS_JUMP   = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOOK,
    ST_DIFF,
    ST_SQR,
    ST_CMP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       load;
    logic       start_upd;
    logic       step_upd;
    logic       look_issue;
    logic       look_mul;
    logic [1:0] look_sel;
    logic       diff_en;
    logic       sqr_en;
    logic       cmp_en;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic have_prev;
    logic full;
    logic front;
    logic pass;
    logic out_busy;
  } status_t;

  // Q15 sine of x (Q30 radians), 13-term Taylor series, rounded and saturated
  function automatic logic [SINE_W-1:0] sine_q15(input logic [63:0] x);
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 12; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        8:       term = term / 64'd272;
        9:       term = term / 64'd342;
        10:      term = term / 64'd420;
        11:      term = term / 64'd506;
        default: term = term / 64'd600;
      endcase
      if ((n % 2) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    q = (sum + 64'sd16384) >>> 15;
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    return q[SINE_W-1:0];
  endfunction

endpackage

`default_nettype wire

[design/srjcd_if.sv]
// Item channel interfaces of the corner detector
`default_nettype none

interface srjcd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        scan_start;

  modport source (output valid, range_mm, scan_start, input ready);
  modport sink   (input valid, range_mm, scan_start, output ready);
endinterface

interface srjcd_out_if;
  logic              valid;
  logic              ready;
  logic signed [16:0] near_x;
  logic signed [16:0] near_y;
  logic signed [16:0] far_x;
  logic signed [16:0] far_y;
  logic              jump_dir;
  logic [9:0]        beam_index;

  modport source (output valid, near_x, near_y, far_x, far_y, jump_dir, beam_index,
                  input ready);
  modport sink   (input valid, near_x, near_y, far_x, far_y, jump_dir, beam_index,
                  output ready);
endinterface

`default_nettype wire

[design/srjcd_datapath.sv]
// Datapath: registers, beam state, sine ROM, shared scaler, gap tests, output register
`default_nettype none

module srjcd_datapath #(
  parameter int unsigned MAX_BEAMS    = srjcd_pkg::MAX_BEAMS_DEF,
  parameter int unsigned SINE_ENTRIES = srjcd_pkg::SINE_ENTRIES_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [srjcd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [srjcd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  wire logic [srjcd_pkg::RANGE_W-1:0]          range_mm_i,
  input  wire logic                                   scan_start_i,
  input  wire srjcd_pkg::cmd_t                        cmd_i,
  output srjcd_pkg::status_t                          status_o,
  input  wire logic                                   out_ready_i,
  output logic                                        out_valid_o,
  output logic signed [srjcd_pkg::COORD_W-1:0]        near_x_o,
  output logic signed [srjcd_pkg::COORD_W-1:0]        near_y_o,
  output logic signed [srjcd_pkg::COORD_W-1:0]        far_x_o,
  output logic signed [srjcd_pkg::COORD_W-1:0]        far_y_o,
  output logic                                        jump_dir_o,
  output logic [srjcd_pkg::BEAM_IDX_W-1:0]            beam_index_o
);

  localparam int unsigned IW   = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
  localparam int unsigned IDXW = $clog2(SINE_ENTRIES + 1);
  localparam int unsigned PW   = 15 + IDXW;
  localparam int unsigned RW   = srjcd_pkg::RANGE_W;
  localparam int unsigned AW   = srjcd_pkg::ANGLE_W;
  localparam int unsigned CW   = srjcd_pkg::COORD_W;
  localparam int unsigned SW   = srjcd_pkg::SINE_W;

  // configuration
  logic [AW-1:0]                 start_angle_q;
  logic [srjcd_pkg::STEP_W-1:0]  angle_step_q;
  logic [RW-1:0]                 gap_min_q;
  logic [RW-1:0]                 near_max_q;
  logic [RW-1:0]                 axis_jump_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_angle_q <= srjcd_pkg::START_ANGLE_RST;
      angle_step_q  <= srjcd_pkg::ANGLE_STEP_RST;
      gap_min_q     <= srjcd_pkg::GAP_MIN_RST;
      near_max_q    <= srjcd_pkg::NEAR_MAX_RST;
      axis_jump_q   <= srjcd_pkg::AXIS_JUMP_RST;
    end else if (cfg_we_i) begin
      case (srjcd_pkg::cfg_reg_e'(cfg_idx_i))
        srjcd_pkg::REG_START_ANGLE: start_angle_q <= cfg_wdata_i[AW-1:0];
        srjcd_pkg::REG_ANGLE_STEP:  angle_step_q  <= cfg_wdata_i[srjcd_pkg::STEP_W-1:0];
        srjcd_pkg::REG_GAP_MIN:     gap_min_q     <= cfg_wdata_i[RW-1:0];
        srjcd_pkg::REG_NEAR_MAX:    near_max_q    <= cfg_wdata_i[RW-1:0];
        srjcd_pkg::REG_AXIS_JUMP:   axis_jump_q   <= cfg_wdata_i[RW-1:0];
        default: ;
      endcase
    end
  end

  // current item
  logic [RW-1:0] cur_range_q;
  logic          cur_start_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_range_q <= range_mm_i;
      cur_start_q <= scan_start_i;
    end
  end

  // beam state
  logic [RW-1:0] prev_range_q;
  logic [AW-1:0] prev_angle_q;
  logic [IW-1:0] prev_index_q;
  logic          have_prev_q;
  logic [AW-1:0] a1;

  assign a1 = prev_angle_q + AW'(angle_step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_range_q <= '0;
      prev_angle_q <= '0;
      prev_index_q <= '0;
      have_prev_q  <= 1'b0;
    end else if (cmd_i.start_upd) begin
      prev_range_q <= cur_range_q;
      prev_angle_q <= start_angle_q;
      prev_index_q <= '0;
      have_prev_q  <= 1'b1;
    end else if (cmd_i.step_upd) begin
      prev_range_q <= cur_range_q;
      prev_angle_q <= a1;
      prev_index_q <= prev_index_q + IW'(1);
    end
  end

  // sine ROM
  logic [SW-1:0] sine_rom [SINE_ENTRIES+1];

  for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_rom
    localparam logic [63:0] ArgX = (64'(k) * 64'd1686629713) / 64'(SINE_ENTRIES);
    assign sine_rom[k] = srjcd_pkg::sine_q15(ArgX);
  end

  // lookup address
  logic [AW-1:0]     look_ang;
  logic [14:0]       look_p;
  logic [PW-1:0]     look_prod;
  logic [IDXW:0]     look_sh;
  logic [IDXW-1:0]   look_idx;

  always_comb begin
    case (cmd_i.look_sel)
      2'd0:    look_ang = prev_angle_q + srjcd_pkg::QUARTER_TURN;
      2'd1:    look_ang = prev_angle_q;
      2'd2:    look_ang = a1 + srjcd_pkg::QUARTER_TURN;
      default: look_ang = a1;
    endcase
    look_p = look_ang[14] ? (15'd16384 - {1'b0, look_ang[13:0]}) : {1'b0, look_ang[13:0]};
    look_prod = PW'(look_p) * PW'(SINE_ENTRIES);
    look_sh   = look_prod[PW-1:14];
    look_idx  = (look_sh > (IDXW+1)'(SINE_ENTRIES)) ? IDXW'(SINE_ENTRIES)
                                                    : look_sh[IDXW-1:0];
  end

  logic [SW-1:0] rom_q;
  logic          neg_q;
  logic [1:0]    sel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.look_issue) begin
      rom_q <= sine_rom[look_idx];
      neg_q <= look_ang[15];
      sel_q <= cmd_i.look_sel;
    end
  end

  // shared scaler: range * |sin| / 32768, rounded half away from zero
  logic [RW-1:0]       mul_rng;
  logic [RW+SW-1:0]    mul_prod;
  logic [31:0]         mul_rnd;
  logic [CW-1:0]       mul_mag;
  logic signed [CW-1:0] coord_q [4];

  always_comb begin
    mul_rng  = sel_q[1] ? cur_range_q : prev_range_q;
    mul_prod = (RW+SW)'(mul_rng) * (RW+SW)'(rom_q);
    mul_rnd  = 32'(mul_prod) + 32'd16384;
    mul_mag  = mul_rnd[31:15];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look_mul) begin
      coord_q[sel_q] <= neg_q ? -signed'(mul_mag) : signed'(mul_mag);
    end
  end

  // differences
  logic signed [CW:0] dx;
  logic signed [CW:0] dy;
  logic [CW-1:0]      adx_q;
  logic [CW-1:0]      ady_q;
  logic [31:0]        lim2_q;

  always_comb begin
    dx = CW'(0) + ((CW+1)'(coord_q[2]) - (CW+1)'(coord_q[0]));
    dy = CW'(0) + ((CW+1)'(coord_q[3]) - (CW+1)'(coord_q[1]));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      adx_q  <= dx[CW] ? CW'(-dx) : CW'(dx);
      ady_q  <= dy[CW] ? CW'(-dy) : CW'(dy);
      lim2_q <= 32'(gap_min_q) * 32'(gap_min_q);
    end
  end

  // squares
  logic [2*CW-1:0] adx2_q;
  logic [2*CW-1:0] ady2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqr_en) begin
      adx2_q <= (2*CW)'(adx_q) * (2*CW)'(adx_q);
      ady2_q <= (2*CW)'(ady_q) * (2*CW)'(ady_q);
    end
  end

  // tests
  logic          rising;
  logic [RW-1:0] smaller;
  logic [2*CW:0] gap2;
  logic          pass_q;

  always_comb begin
    rising  = prev_range_q < cur_range_q;
    smaller = rising ? prev_range_q : cur_range_q;
    gap2    = (2*CW+1)'(adx2_q) + (2*CW+1)'(ady2_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en) begin
      pass_q <= (gap2 > (2*CW+1)'(lim2_q)) && (smaller <= near_max_q) &&
                ((adx_q >= CW'(axis_jump_q)) || (ady_q >= CW'(axis_jump_q)));
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      near_x_o     <= rising ? coord_q[0] : coord_q[2];
      near_y_o     <= rising ? coord_q[1] : coord_q[3];
      far_x_o      <= rising ? coord_q[2] : coord_q[0];
      far_y_o      <= rising ? coord_q[3] : coord_q[1];
      jump_dir_o   <= !rising;
      beam_index_o <= srjcd_pkg::BEAM_IDX_W'(prev_index_q);
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o.start     = cur_start_q;
    status_o.have_prev = have_prev_q;
    status_o.full      = ((IW+1)'(prev_index_q) + (IW+1)'(1)) >= (IW+1)'(MAX_BEAMS);
    status_o.front     = (prev_angle_q < srjcd_pkg::FRONT_LOW_END) ||
                         (prev_angle_q > srjcd_pkg::FRONT_HIGH_END);
    status_o.pass      = pass_q;
    status_o.out_busy  = out_valid_q && !out_ready_i;
  end

endmodule

`default_nettype wire

[design/srjcd_ctrl.sv]
// Controller: sequences checks, sine lookups, tests and result hand-off per item
`default_nettype none

module srjcd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire srjcd_pkg::status_t  status_i,
  output srjcd_pkg::cmd_t          cmd_o
);

`include "scan_range_jump_corner_detector_core_assert.svh"

  srjcd_pkg::state_e state_q, state_d;
  logic [2:0]        cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srjcd_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_q == srjcd_pkg::ST_LOOK) ? cnt_q + 3'd1 : 3'd0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      srjcd_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = srjcd_pkg::ST_CHECK;
      end
      srjcd_pkg::ST_CHECK: begin
        if (status_i.start || !status_i.have_prev || status_i.full || !status_i.front) begin
          state_d = srjcd_pkg::ST_IDLE;
        end else begin
          state_d = srjcd_pkg::ST_LOOK;
        end
      end
      srjcd_pkg::ST_LOOK: begin
        if (cnt_q == srjcd_pkg::LOOK_LAST) state_d = srjcd_pkg::ST_DIFF;
      end
      srjcd_pkg::ST_DIFF: state_d = srjcd_pkg::ST_SQR;
      srjcd_pkg::ST_SQR:  state_d = srjcd_pkg::ST_CMP;
      srjcd_pkg::ST_CMP:  state_d = srjcd_pkg::ST_EMIT;
      srjcd_pkg::ST_EMIT: begin
        if (!status_i.pass || !status_i.out_busy) state_d = srjcd_pkg::ST_IDLE;
      end
      default: state_d = srjcd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      srjcd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      srjcd_pkg::ST_CHECK: begin
        if (status_i.start) begin
          cmd_o.start_upd = 1'b1;
        end else if (status_i.have_prev && !status_i.full && !status_i.front) begin
          cmd_o.step_upd = 1'b1;
        end
      end
      srjcd_pkg::ST_LOOK: begin
        cmd_o.look_issue = cnt_q != srjcd_pkg::LOOK_LAST;
        cmd_o.look_mul   = cnt_q != 3'd0;
        cmd_o.look_sel   = cnt_q[1:0];
      end
      srjcd_pkg::ST_DIFF: cmd_o.diff_en = 1'b1;
      srjcd_pkg::ST_SQR:  cmd_o.sqr_en  = 1'b1;
      srjcd_pkg::ST_CMP:  cmd_o.cmp_en  = 1'b1;
      srjcd_pkg::ST_EMIT: begin
        if (!status_i.pass) begin
          cmd_o.step_upd = 1'b1;
        end else if (!status_i.out_busy) begin
          cmd_o.step_upd = 1'b1;
          cmd_o.out_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  `SRJCD_ASSERT_NEXT(a_accept_to_check, clk_i, rst_ni, in_valid_i && in_ready_o,
                     state_q == srjcd_pkg::ST_CHECK, "accepted item did not start a check")
  `SRJCD_ASSERT_NOW(a_load_only_free, clk_i, rst_ni, cmd_o.out_load,
                    !status_i.out_busy && status_i.pass, "result loaded over a waiting item")
  `SRJCD_ASSERT_NEXT(a_look_to_diff, clk_i, rst_ni,
                     state_q == srjcd_pkg::ST_LOOK && cnt_q == srjcd_pkg::LOOK_LAST,
                     state_q == srjcd_pkg::ST_DIFF, "lookup phase overran")

endmodule

`default_nettype wire

[design/scan_range_jump_corner_detector_core.sv]
// Top level of the scan range jump corner detector
//
// Input channel in_i carries one range sample per item; scan_start marks
// beam 0 of a scan. Output channel out_o carries one corner item (near
// point, far point, jump direction, beam index) when the pair formed by the
// previous and the current beam passes the gap, near and axis tests.
// Registers are to be written through cfg_we_i / cfg_idx_i / cfg_wdata_i
// only while the block is idle, by the user; the block does not enforce it.
// Throughput: one item at a time. A scan start, a sample outside a scan,
// a sample beyond the beam limit or a pair whose first beam faces backwards
// ends in the check state, after which the next item can be accepted; a
// tested pair goes on through four lookups in turn on the single sine ROM
// port and shared scaling multiplier, then difference, square, compare and
// emit states. A corner item is loaded into the output register in emit.
// The result sits in an output register, so the next item is accepted while
// it waits; a further corner waits until that register is taken.
// Reset sets the control and configuration registers to their reset values
// and forgets the scan: samples are ignored until the next scan start.
`default_nettype none

module scan_range_jump_corner_detector_core #(
  parameter int unsigned MAX_BEAMS    = srjcd_pkg::MAX_BEAMS_DEF,
  parameter int unsigned SINE_ENTRIES = srjcd_pkg::SINE_ENTRIES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [srjcd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [srjcd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  srjcd_in_if.sink                              in_i,
  srjcd_out_if.source                           out_o
);

  srjcd_pkg::cmd_t    cmd;
  srjcd_pkg::status_t status;
  logic               in_ready;

  assign in_i.ready = in_ready;

  srjcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srjcd_datapath #(
    .MAX_BEAMS    (MAX_BEAMS),
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .range_mm_i   (in_i.range_mm),
    .scan_start_i (in_i.scan_start),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .near_x_o     (out_o.near_x),
    .near_y_o     (out_o.near_y),
    .far_x_o      (out_o.far_x),
    .far_y_o      (out_o.far_y),
    .jump_dir_o   (out_o.jump_dir),
    .beam_index_o (out_o.beam_index)
  );

endmodule

`default_nettype wire

[dv/srjcd_corner_checker.sv]
// Corner detector checker: predicts corner items from the beam channel and compares them
`timescale 1ns / 100ps

module srjcd_corner_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [srjcd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [srjcd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  srjcd_in_if                              beam_mon,
  srjcd_out_if                             corner_mon,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               beam_count_o,
  output int                               corner_count_o
);

  localparam int unsigned TAB_LEN = srjcd_pkg::SINE_ENTRIES_DEF;
  localparam int unsigned BEAM_LIMIT = srjcd_pkg::MAX_BEAMS_DEF;

  typedef struct packed {
    logic signed [16:0] near_x;
    logic signed [16:0] near_y;
    logic signed [16:0] far_x;
    logic signed [16:0] far_y;
    logic               jump_dir;
    logic [9:0]         beam_index;
  } corner_t;

  int          sine_tab [0:TAB_LEN];
  corner_t     expected_corners [$];
  corner_t     found;
  corner_t     want;

  logic [15:0] start_angle_q;
  logic [14:0] angle_step_q;
  logic [15:0] gap_min_q;
  logic [15:0] near_max_q;
  logic [15:0] axis_jump_q;

  logic [15:0] last_range;
  logic [15:0] last_angle;
  logic [15:0] next_angle;
  int unsigned beam_no;
  bit          have_scan;

  // Q15 quarter-wave table from a 13-term Q30 series
  initial begin
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint          q;
    for (int k = 0; k <= TAB_LEN; k++) begin
      x = (longint'(k) * 64'd1686629713) / TAB_LEN;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 12; n++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      q = (sum + 16384) >>> 15;
      if (q > 32767) begin
        q = 32767;
      end
      sine_tab[k] = int'(q);
    end
  end

  function automatic int q15_sine(input logic [15:0] a);
    int unsigned p;
    int unsigned idx;
    p = {18'd0, a[13:0]};
    if (a[14]) begin
      p = 16384 - p;
    end
    idx = (p * TAB_LEN) >> 14;
    if (idx > TAB_LEN) begin
      idx = TAB_LEN;
    end
    return a[15] ? -sine_tab[idx] : sine_tab[idx];
  endfunction

  function automatic int to_mm(input logic [15:0] r, input int s);
    int unsigned mag;
    int unsigned m;
    mag = (s < 0) ? -s : s;
    m = (r * mag + 32'd16384) >> 15;
    return (s < 0) ? -int'(m) : int'(m);
  endfunction

  function automatic bit find_corner(input logic [15:0] r0, input logic [15:0] r1,
                                     input logic [15:0] a0, input logic [15:0] a1,
                                     input logic [9:0] idx, output corner_t c);
    int              x0, y0, x1, y1, adx, ady;
    longint unsigned gap2;
    longint unsigned lim2;
    logic [15:0]     shorter;
    logic [15:0]     a0c, a1c;
    a0c = a0 + srjcd_pkg::QUARTER_TURN;
    a1c = a1 + srjcd_pkg::QUARTER_TURN;
    x0 = to_mm(r0, q15_sine(a0c));
    y0 = to_mm(r0, q15_sine(a0));
    x1 = to_mm(r1, q15_sine(a1c));
    y1 = to_mm(r1, q15_sine(a1));
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;
    gap2 = longint'(adx) * adx + longint'(ady) * ady;
    lim2 = longint'(gap_min_q) * gap_min_q;
    shorter = (r0 < r1) ? r0 : r1;
    c = '0;
    if (!(gap2 > lim2 && shorter <= near_max_q &&
          (adx >= int'(axis_jump_q) || ady >= int'(axis_jump_q)))) begin
      return 1'b0;
    end
    if (r0 < r1) begin
      c.near_x = x0[16:0];
      c.near_y = y0[16:0];
      c.far_x = x1[16:0];
      c.far_y = y1[16:0];
      c.jump_dir = 1'b0;
    end else begin
      c.near_x = x1[16:0];
      c.near_y = y1[16:0];
      c.far_x = x0[16:0];
      c.far_y = y0[16:0];
      c.jump_dir = 1'b1;
    end
    c.beam_index = idx;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_angle_q = 16'h8000;
      angle_step_q = 15'd182;
      gap_min_q = 16'd150;
      near_max_q = 16'd5000;
      axis_jump_q = 16'd500;
      last_range = '0;
      last_angle = '0;
      beam_no = 0;
      have_scan = 1'b0;
      expected_corners.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          srjcd_pkg::REG_START_ANGLE: start_angle_q = cfg_wdata_i;
          srjcd_pkg::REG_ANGLE_STEP:  angle_step_q = cfg_wdata_i[14:0];
          srjcd_pkg::REG_GAP_MIN:     gap_min_q = cfg_wdata_i;
          srjcd_pkg::REG_NEAR_MAX:    near_max_q = cfg_wdata_i;
          srjcd_pkg::REG_AXIS_JUMP:   axis_jump_q = cfg_wdata_i;
          default: ;
        endcase
      end

      if (beam_mon.valid && beam_mon.ready) begin
        beam_count_o++;
        if (beam_mon.scan_start) begin
          last_range = beam_mon.range_mm;
          last_angle = start_angle_q;
          beam_no = 0;
          have_scan = 1'b1;
        end else if (have_scan && beam_no + 1 < BEAM_LIMIT) begin
          next_angle = last_angle + {1'b0, angle_step_q};
          // pair counts only when its first beam faces forward
          if (last_angle < srjcd_pkg::FRONT_LOW_END ||
              last_angle > srjcd_pkg::FRONT_HIGH_END) begin
            if (find_corner(last_range, beam_mon.range_mm, last_angle, next_angle,
                            beam_no[9:0], found)) begin
              expected_corners = {expected_corners, found};
            end
          end
          last_range = beam_mon.range_mm;
          last_angle = next_angle;
          beam_no++;
        end
      end

      if (corner_mon.valid && corner_mon.ready) begin
        if (expected_corners.size() == 0) begin
          $error("corner item with none expected: beam_index %0d", corner_mon.beam_index);
          fail_count_o++;
        end else begin
          want = expected_corners.pop_front();
          corner_count_o++;
          check_field("near_x", 32'(want.near_x), 32'(corner_mon.near_x));
          check_field("near_y", 32'(want.near_y), 32'(corner_mon.near_y));
          check_field("far_x", 32'(want.far_x), 32'(corner_mon.far_x));
          check_field("far_y", 32'(want.far_y), 32'(corner_mon.far_y));
          check_field("jump_dir", {31'd0, want.jump_dir}, {31'd0, corner_mon.jump_dir});
          check_field("beam_index", {22'd0, want.beam_index}, {22'd0, corner_mon.beam_index});
        end
      end
    end
    pending_o = expected_corners.size();
  end

endmodule

[dv/testbench.sv]
// Testbench top for the corner detector: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1350;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [srjcd_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [srjcd_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  int fail_count;
  int pending;
  int beam_count;
  int corner_count;
  int cycle_count = 0;
  int items_sent = 0;
  int settings_count = 0;
  bit calm = 1'b0;

  srjcd_in_if  beam_ch ();
  srjcd_out_if corner_ch ();

  scan_range_jump_corner_detector_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (beam_ch),
    .out_o       (corner_ch)
  );

  srjcd_corner_checker corner_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .beam_mon       (beam_ch),
    .corner_mon     (corner_ch),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .beam_count_o   (beam_count),
    .corner_count_o (corner_count)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("scan_range_jump_corner_detector_core verification failed");
      $finish;
    end
  end

  function automatic int pause_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] next_range(input logic [15:0] last);
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      v = int'(last) + int'($urandom_range(0, 60)) - 30;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
    end else if (pick < 82) begin
      v = $urandom_range(100, 6000);
    end else if (pick < 92) begin
      v = $urandom_range(0, 65535);
    end else if (pick < 96) begin
      v = 0;
    end else begin
      v = 65535;
    end
    return v[15:0];
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_beam(input logic [15:0] r, input logic s);
    int gap;
    beam_ch.valid = 1'b1;
    beam_ch.range_mm = r;
    beam_ch.scan_start = s;
    @(posedge clk_i);
    while (!beam_ch.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
    gap = calm ? 0 : pause_len();
    if (gap > 0) begin
      beam_ch.valid = 1'b0;
      beam_ch.range_mm = 16'($urandom);
      beam_ch.scan_start = 1'($urandom);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input srjcd_pkg::cfg_reg_e idx, input logic [15:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // drain all corners, then let the last item clear the pipeline
  task automatic settle();
    beam_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [15:0] start_a, input logic [15:0] step,
                          input logic [15:0] gap, input logic [15:0] near,
                          input logic [15:0] axis);
    write_reg(srjcd_pkg::REG_START_ANGLE, start_a);
    write_reg(srjcd_pkg::REG_ANGLE_STEP, step);
    write_reg(srjcd_pkg::REG_GAP_MIN, gap);
    write_reg(srjcd_pkg::REG_NEAR_MAX, near);
    write_reg(srjcd_pkg::REG_AXIS_JUMP, axis);
    settings_count++;
  endtask

  task automatic run_scan(input int len, input bit noisy);
    logic [15:0] r;
    r = $urandom_range(0, 3) == 0 ? next_range(16'd0) : 16'($urandom_range(100, 6000));
    send_beam(r, 1'b1);
    for (int i = 1; i < len; i++) begin
      if (noisy && $urandom_range(0, 99) < 6) begin
        // restart in mid scan
        r = 16'($urandom);
        send_beam(r, 1'b1);
      end else begin
        r = next_range(r);
        send_beam(r, 1'b0);
      end
    end
  endtask

  // output side back-pressure
  initial begin
    int hold;
    corner_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (calm || $urandom_range(0, 2) != 0) begin
        corner_ch.ready = 1'b1;
        hold = $urandom_range(1, 20);
      end else begin
        corner_ch.ready = 1'b0;
        hold = pause_len() + 1;
      end
      repeat (hold - 1) @(negedge clk_i);
    end
  end

  initial begin
    int phase;
    logic [15:0] start_a, step, gap, near, axis;
    beam_ch.valid = 1'b0;
    beam_ch.range_mm = '0;
    beam_ch.scan_start = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // reset settings: beam before any scan, then a backward-facing pair
    send_beam(16'd100, 1'b0);
    send_beam(16'hFFFF, 1'b1);
    send_beam(16'd0, 1'b0);
    send_beam(16'd4000, 1'b0);
    settle();

    // first beam on the rear boundary, then range extremes in front
    set_regs(16'hC000, 16'd1, 16'd0, 16'hFFFF, 16'd0);
    send_beam(16'd1000, 1'b1);
    send_beam(16'd5000, 1'b0);
    send_beam(16'd1000, 1'b0);
    send_beam(16'hFFFF, 1'b0);
    send_beam(16'hFFFF, 1'b0);
    send_beam(16'd0, 1'b0);
    send_beam(16'd0, 1'b0);
    settle();

    // half-turn steps: angle wraps back into the front
    set_regs(16'd16383, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beam(16'hFFFF, 1'b1);
    send_beam(16'hFFFF, 1'b0);
    send_beam(16'hFFFF, 1'b0);
    send_beam(16'hFFFF, 1'b0);
    settle();

    // zero near limit
    set_regs(16'd0, 16'd1000, 16'd0, 16'd0, 16'd0);
    send_beam(16'd0, 1'b1);
    send_beam(16'd40000, 1'b0);
    send_beam(16'd1, 1'b0);
    send_beam(16'd0, 1'b0);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      calm = (phase % 4 == 3);
      if (phase == 2) begin
        // one scan past the beam limit, up to several turns of angle
        start_a = 16'($urandom_range(49153, 65535));
        set_regs(start_a, 16'($urandom_range(60, 400)), 16'($urandom_range(100, 400)),
                 16'($urandom_range(3000, 20000)), 16'($urandom_range(100, 800)));
        run_scan(1030, 1'b0);
      end else begin
        case ($urandom_range(0, 7))
          0:       start_a = 16'($urandom);
          1:       start_a = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
          default: start_a = $urandom_range(0, 1) ? 16'($urandom_range(49153, 65535))
                                                  : 16'($urandom_range(0, 12000));
        endcase
        case ($urandom_range(0, 7))
          0:       step = 16'd32767;
          1:       step = 16'd1;
          2:       step = 16'($urandom_range(1, 32767));
          default: step = 16'($urandom_range(16, 400));
        endcase
        case ($urandom_range(0, 7))
          0:       gap = 16'd0;
          1:       gap = 16'hFFFF;
          default: gap = 16'($urandom_range(0, 800));
        endcase
        case ($urandom_range(0, 7))
          0:       near = 16'd0;
          1:       near = 16'hFFFF;
          default: near = 16'($urandom_range(800, 20000));
        endcase
        case ($urandom_range(0, 7))
          0:       axis = 16'd0;
          1:       axis = 16'hFFFF;
          default: axis = 16'($urandom_range(0, 1500));
        endcase
        set_regs(start_a, step, gap, near, axis);
        repeat ($urandom_range(1, 3)) run_scan($urandom_range(2, 40), 1'b1);
      end
      phase++;
    end

    beam_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (30) @(posedge clk_i);
    $display("Run covered %0d beam items over %0d register settings,", beam_count,
             settings_count);
    $display("including one scan past the beam limit; %0d corner items compared.",
             corner_count);
    if (fail_count == 0 && pending == 0) begin
      $display("scan_range_jump_corner_detector_core verification clean");
    end else begin
      $display("scan_range_jump_corner_detector_core verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/srjcd_pkg.sv
design/srjcd_if.sv
design/srjcd_datapath.sv
design/srjcd_ctrl.sv
design/scan_range_jump_corner_detector_core.sv
dv/srjcd_corner_checker.sv
dv/testbench.sv
